[hw/rtl/mcb_pkg.sv]
// Shared types and constants for the mirrored, clipped blit generator.
// Used by mcb_job, mcb_addr and the top level; depends on nothing.
package mcb_pkg;

    // Default geometry of the block
    localparam int COORD_BITS_DEF = 12;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 24;

    // Configuration registers: fixed width, reset value and index codes
    localparam int CFG_BITS       = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 13'd256;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DST_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DST_HEIGHT = 2'd2;

    // Input beat kinds
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } mcb_cmd_t;

    // Per-beat control carried from the job stage to the address stage
    typedef struct packed {
        logic step;     // active step: addresses and write enable are computed
        logic last;     // final position, empty job or idle step
        logic busy;     // positions of the job remain after this beat
        logic overlay;  // zero pixels are transparent
    } mcb_flags_t;

endpackage

[hw/rtl/mcb_job.sv]
// Job stage of the blit generator: latches the job on a start beat, walks the
// rectangle in row-major order and registers the source and destination coordinates.
// Depends on mcb_pkg.
module mcb_job import mcb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Incoming beat
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mcb_cmd_t              in_cmd,
    input  logic [COORD_BITS-1:0] in_src_x,
    input  logic [COORD_BITS-1:0] in_src_y,
    input  logic [COORD_BITS+1:0] in_rect_width,
    input  logic [COORD_BITS+1:0] in_rect_height,
    input  logic [COORD_BITS:0]   in_dst_x,
    input  logic [COORD_BITS:0]   in_dst_y,
    input  logic                  in_overlay_mode,
    input  logic [PIXEL_BITS-1:0] in_pixel,
    // Registered beat towards the address stage
    output logic                  st_valid,
    input  logic                  st_ready,
    output logic [COORD_BITS:0]   st_src_col,
    output logic [COORD_BITS:0]   st_src_row,
    output logic [COORD_BITS+1:0] st_dst_col,
    output logic [COORD_BITS+1:0] st_dst_row,
    output logic [PIXEL_BITS-1:0] st_pixel,
    output mcb_flags_t            st_flags
);

    localparam logic [COORD_BITS:0] SIZE_LIMIT = {1'b1, {COORD_BITS{1'b0}}};

    // Saturating magnitude of a signed size
    function automatic logic [COORD_BITS:0] size_mag(input logic [COORD_BITS+1:0] v);
        logic [COORD_BITS+1:0] a;
        a = v[COORD_BITS+1] ? (~v + 1'b1) : v;
        if (a > {1'b0, SIZE_LIMIT}) begin
            size_mag = SIZE_LIMIT;
        end else begin
            size_mag = a[COORD_BITS:0];
        end
    endfunction

    // Job state
    logic [COORD_BITS-1:0] src_col_reg, src_col_next;
    logic [COORD_BITS-1:0] src_row_reg, src_row_next;
    logic [COORD_BITS:0]   width_reg, width_next;
    logic [COORD_BITS:0]   height_reg, height_next;
    logic                  mirror_cols_reg, mirror_cols_next;
    logic                  mirror_rows_reg, mirror_rows_next;
    logic [COORD_BITS:0]   dst_col_reg, dst_col_next;
    logic [COORD_BITS:0]   dst_row_reg, dst_row_next;
    logic                  overlay_reg, overlay_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic                  active_reg, active_next;

    // Stage register
    logic                  st_valid_reg;
    logic [COORD_BITS:0]   st_src_col_reg, st_src_col_next;
    logic [COORD_BITS:0]   st_src_row_reg, st_src_row_next;
    logic [COORD_BITS+1:0] st_dst_col_reg, st_dst_col_next;
    logic [COORD_BITS+1:0] st_dst_row_reg, st_dst_row_next;
    logic [PIXEL_BITS-1:0] st_pixel_reg;
    mcb_flags_t            st_flags_reg, st_flags_next;

    logic                  accept;
    logic [COORD_BITS:0]   col_inc;
    logic [COORD_BITS:0]   row_inc;
    logic [COORD_BITS:0]   col_off;
    logic [COORD_BITS:0]   row_off;

    assign in_ready = !st_valid_reg || st_ready;
    assign accept   = in_valid && in_ready;

    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    // Mirrored offsets count back from the far edge
    assign col_off = mirror_cols_reg ? (width_reg - 1'b1 - {1'b0, col_reg})
                                     : {1'b0, col_reg};
    assign row_off = mirror_rows_reg ? (height_reg - 1'b1 - {1'b0, row_reg})
                                     : {1'b0, row_reg};

    // Latch the job or advance the walk for an accepted beat
    always_comb begin
        src_col_next     = src_col_reg;
        src_row_next     = src_row_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        mirror_cols_next = mirror_cols_reg;
        mirror_rows_next = mirror_rows_reg;
        dst_col_next     = dst_col_reg;
        dst_row_next     = dst_row_reg;
        overlay_next     = overlay_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        active_next      = active_reg;
        st_src_col_next  = '0;
        st_src_row_next  = '0;
        st_dst_col_next  = '0;
        st_dst_row_next  = '0;
        st_flags_next    = '0;
        if (accept) begin
            case (in_cmd)
                CMD_START: begin
                    src_col_next       = in_src_x;
                    src_row_next       = in_src_y;
                    width_next         = size_mag(in_rect_width);
                    height_next        = size_mag(in_rect_height);
                    mirror_cols_next   = in_rect_width[COORD_BITS+1];
                    mirror_rows_next   = in_rect_height[COORD_BITS+1];
                    dst_col_next       = in_dst_x;
                    dst_row_next       = in_dst_y;
                    overlay_next       = in_overlay_mode;
                    col_next           = '0;
                    row_next           = '0;
                    active_next        = (width_next != '0) && (height_next != '0);
                    st_flags_next.last = !active_next;
                    st_flags_next.busy = active_next;
                end
                CMD_STEP: begin
                    if (!active_reg) begin
                        st_flags_next.last = 1'b1;
                    end else begin
                        st_src_col_next       = {1'b0, src_col_reg} + col_off;
                        st_src_row_next       = {1'b0, src_row_reg} + row_off;
                        st_dst_col_next       = {dst_col_reg[COORD_BITS], dst_col_reg}
                                                + {2'b00, col_reg};
                        st_dst_row_next       = {dst_row_reg[COORD_BITS], dst_row_reg}
                                                + {2'b00, row_reg};
                        st_flags_next.step    = 1'b1;
                        st_flags_next.overlay = overlay_reg;
                        if (col_inc >= width_reg) begin
                            col_next = '0;
                            if (row_inc >= height_reg) begin
                                row_next           = '0;
                                active_next        = 1'b0;
                                st_flags_next.last = 1'b1;
                            end else begin
                                row_next = row_inc[COORD_BITS-1:0];
                            end
                        end else begin
                            col_next = col_inc[COORD_BITS-1:0];
                        end
                        st_flags_next.busy = active_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold job state and stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg     <= '0;
            src_row_reg     <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            mirror_cols_reg <= 1'b0;
            mirror_rows_reg <= 1'b0;
            dst_col_reg     <= '0;
            dst_row_reg     <= '0;
            overlay_reg     <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            active_reg      <= 1'b0;
            st_valid_reg    <= 1'b0;
        end else begin
            src_col_reg     <= src_col_next;
            src_row_reg     <= src_row_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            mirror_cols_reg <= mirror_cols_next;
            mirror_rows_reg <= mirror_rows_next;
            dst_col_reg     <= dst_col_next;
            dst_row_reg     <= dst_row_next;
            overlay_reg     <= overlay_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            active_reg      <= active_next;
            if (in_ready) begin
                st_valid_reg <= in_valid;
            end
        end
    end

    // Load the stage payload on each accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_src_col_reg <= st_src_col_next;
            st_src_row_reg <= st_src_row_next;
            st_dst_col_reg <= st_dst_col_next;
            st_dst_row_reg <= st_dst_row_next;
            st_pixel_reg   <= in_pixel;
            st_flags_reg   <= st_flags_next;
        end
    end

    assign st_valid   = st_valid_reg;
    assign st_src_col = st_src_col_reg;
    assign st_src_row = st_src_row_reg;
    assign st_dst_col = st_dst_col_reg;
    assign st_dst_row = st_dst_row_reg;
    assign st_pixel   = st_pixel_reg;
    assign st_flags   = st_flags_reg;

endmodule

[hw/rtl/mcb_addr.sv]
// Address stage of the blit generator: one multiply-add per address, clip test,
// colour key, and the result register that faces the output channel.
// Depends on mcb_pkg.
module mcb_addr import mcb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Image geometry
    input  logic [CFG_BITS-1:0]   src_pitch,
    input  logic [CFG_BITS-1:0]   dst_width,
    input  logic [CFG_BITS-1:0]   dst_height,
    // Beat from the job stage
    input  logic                  st_valid,
    output logic                  st_ready,
    input  logic [COORD_BITS:0]   st_src_col,
    input  logic [COORD_BITS:0]   st_src_row,
    input  logic [COORD_BITS+1:0] st_dst_col,
    input  logic [COORD_BITS+1:0] st_dst_row,
    input  logic [PIXEL_BITS-1:0] st_pixel,
    input  mcb_flags_t            st_flags,
    // Result beat
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [ADDR_BITS-1:0]  res_src_addr,
    output logic [ADDR_BITS-1:0]  res_dst_addr,
    output logic                  res_write_enable,
    output logic [PIXEL_BITS-1:0] res_pixel,
    output logic                  res_last,
    output logic                  res_busy
);

    localparam int PROD_W = COORD_BITS + 1 + CFG_BITS;
    localparam int SUM_W  = (PROD_W + 1 > ADDR_BITS) ? PROD_W + 1 : ADDR_BITS;
    localparam int CMP_W  = (COORD_BITS + 1 > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS;

    logic                  res_valid_reg;
    logic [ADDR_BITS-1:0]  src_addr_reg, src_addr_next;
    logic [ADDR_BITS-1:0]  dst_addr_reg, dst_addr_next;
    logic                  we_reg, we_next;
    logic [PIXEL_BITS-1:0] pixel_reg;
    logic                  last_reg;
    logic                  busy_reg;

    logic                  take;
    logic                  inside_x;
    logic                  inside_y;
    logic [PROD_W-1:0]     s_prod;
    logic [PROD_W-1:0]     d_prod;
    logic [SUM_W-1:0]      s_sum;
    logic [SUM_W-1:0]      d_sum;

    assign st_ready = !res_valid_reg || res_ready;
    assign take     = st_valid && st_ready;

    // Clip against the destination image
    assign inside_x = !st_dst_col[COORD_BITS+1]
                      && (CMP_W'(st_dst_col[COORD_BITS:0]) < CMP_W'(dst_width));
    assign inside_y = !st_dst_row[COORD_BITS+1]
                      && (CMP_W'(st_dst_row[COORD_BITS:0]) < CMP_W'(dst_height));

    // Row times pitch plus column, wrapped to the address width
    assign s_prod = PROD_W'(st_src_row) * PROD_W'(src_pitch);
    assign d_prod = PROD_W'(st_dst_row[COORD_BITS:0]) * PROD_W'(dst_width);
    assign s_sum  = SUM_W'(s_prod) + SUM_W'(st_src_col);
    assign d_sum  = SUM_W'(d_prod) + SUM_W'(st_dst_col[COORD_BITS:0]);

    // Zero addresses and enable off active steps, and dst_addr and we if clipped
    always_comb begin
        src_addr_next = '0;
        dst_addr_next = '0;
        we_next       = 1'b0;
        if (st_flags.step) begin
            src_addr_next = s_sum[ADDR_BITS-1:0];
            if (inside_x && inside_y) begin
                dst_addr_next = d_sum[ADDR_BITS-1:0];
                we_next       = !st_flags.overlay || (st_pixel != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (st_ready) begin
            res_valid_reg <= st_valid;
        end
    end

    // Load the result beat
    always_ff @(posedge aclk) begin
        if (take) begin
            src_addr_reg <= src_addr_next;
            dst_addr_reg <= dst_addr_next;
            we_reg       <= we_next;
            pixel_reg    <= st_pixel;
            last_reg     <= st_flags.last;
            busy_reg     <= st_flags.busy;
        end
    end

    assign res_valid        = res_valid_reg;
    assign res_src_addr     = src_addr_reg;
    assign res_dst_addr     = dst_addr_reg;
    assign res_write_enable = we_reg;
    assign res_pixel        = pixel_reg;
    assign res_last         = last_reg;
    assign res_busy         = busy_reg;

endmodule

[hw/rtl/mirrored_clipped_blit_generator.sv]
// Mirrored, clipped blit generator with a colour key: top level.
// Holds the image geometry registers and wires mcb_job and mcb_addr to the ports.
// Depends on mcb_pkg, mcb_job and mcb_addr.
//
// Usage: send a start beat (s_tuser = 0) carrying the source rectangle, the
// destination point and the overlay mode, then one step beat (s_tuser = 1) per
// position. Each step beat carries the source pixel read at the source address
// that the result of that same step reports. Every input beat gives
// exactly one result beat on the m_ channel; m_tlast marks the final position
// of a job, an empty job or a step with no job left.
// Each accepted input beat passes the job stage register, then the result
// register, before its result can be taken. Throughput: one beat per cycle while
// m_tready stays high; the walk counters update in the same cycle a beat is taken.
// Stalls: while m_tready is low the result register holds, the job stage can
// still take one more beat, and s_tready falls only when both are full.
// Configuration: cfg_ready is always high; write the geometry while idle.
// Reset (aresetn low, synchronous): no job, both stages empty, and all three
// geometry registers back to 256.
module mirrored_clipped_blit_generator import mcb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int S_DATA_W   = ((6 * COORD_BITS + 7 + PIXEL_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((2 * ADDR_BITS + PIXEL_BITS + 2 + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,
    // Input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // src_x, src_y, rect_width, rect_height, dst_x, dst_y, overlay_mode, pixel_in
    input  logic [S_DATA_W-1:0]       s_tdata,
    // command
    input  logic                      s_tuser,
    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // src_addr, dst_addr, write_enable, pixel_out, busy_res
    output logic [M_DATA_W-1:0]       m_tdata,
    output logic                      m_tlast
);

    // Field offsets within s_tdata
    localparam int SX_LO = 0;
    localparam int SY_LO = COORD_BITS;
    localparam int RW_LO = 2 * COORD_BITS;
    localparam int RH_LO = 3 * COORD_BITS + 2;
    localparam int DX_LO = 4 * COORD_BITS + 4;
    localparam int DY_LO = 5 * COORD_BITS + 5;
    localparam int OV_LO = 6 * COORD_BITS + 6;
    localparam int PX_LO = 6 * COORD_BITS + 7;

    // Field offsets within m_tdata
    localparam int SA_LO = 0;
    localparam int DA_LO = ADDR_BITS;
    localparam int WE_LO = 2 * ADDR_BITS;
    localparam int PO_LO = 2 * ADDR_BITS + 1;
    localparam int BZ_LO = 2 * ADDR_BITS + 1 + PIXEL_BITS;

    logic [CFG_BITS-1:0]   src_image_width_reg;
    logic [CFG_BITS-1:0]   dst_image_width_reg;
    logic [CFG_BITS-1:0]   dst_image_height_reg;

    logic                  st_valid;
    logic                  st_ready;
    logic [COORD_BITS:0]   st_src_col;
    logic [COORD_BITS:0]   st_src_row;
    logic [COORD_BITS+1:0] st_dst_col;
    logic [COORD_BITS+1:0] st_dst_row;
    logic [PIXEL_BITS-1:0] st_pixel;
    mcb_flags_t            st_flags;

    logic [ADDR_BITS-1:0]  res_src_addr;
    logic [ADDR_BITS-1:0]  res_dst_addr;
    logic                  res_write_enable;
    logic [PIXEL_BITS-1:0] res_pixel;
    logic                  res_busy;

    assign cfg_ready = 1'b1;

    // Geometry registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_image_width_reg  <= CFG_RESET;
            dst_image_width_reg  <= CFG_RESET;
            dst_image_height_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_image_width_reg  <= cfg_data;
                CFG_DST_WIDTH:  dst_image_width_reg  <= cfg_data;
                CFG_DST_HEIGHT: dst_image_height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    mcb_job #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_job (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_cmd          (mcb_cmd_t'(s_tuser)),
        .in_src_x        (s_tdata[SX_LO +: COORD_BITS]),
        .in_src_y        (s_tdata[SY_LO +: COORD_BITS]),
        .in_rect_width   (s_tdata[RW_LO +: COORD_BITS + 2]),
        .in_rect_height  (s_tdata[RH_LO +: COORD_BITS + 2]),
        .in_dst_x        (s_tdata[DX_LO +: COORD_BITS + 1]),
        .in_dst_y        (s_tdata[DY_LO +: COORD_BITS + 1]),
        .in_overlay_mode (s_tdata[OV_LO]),
        .in_pixel        (s_tdata[PX_LO +: PIXEL_BITS]),
        .st_valid        (st_valid),
        .st_ready        (st_ready),
        .st_src_col      (st_src_col),
        .st_src_row      (st_src_row),
        .st_dst_col      (st_dst_col),
        .st_dst_row      (st_dst_row),
        .st_pixel        (st_pixel),
        .st_flags        (st_flags)
    );

    mcb_addr #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_addr (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .src_pitch        (src_image_width_reg),
        .dst_width        (dst_image_width_reg),
        .dst_height       (dst_image_height_reg),
        .st_valid         (st_valid),
        .st_ready         (st_ready),
        .st_src_col       (st_src_col),
        .st_src_row       (st_src_row),
        .st_dst_col       (st_dst_col),
        .st_dst_row       (st_dst_row),
        .st_pixel         (st_pixel),
        .st_flags         (st_flags),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .res_src_addr     (res_src_addr),
        .res_dst_addr     (res_dst_addr),
        .res_write_enable (res_write_enable),
        .res_pixel        (res_pixel),
        .res_last         (m_tlast),
        .res_busy         (res_busy)
    );

    // Pack the result beat, padding with zeros
    always_comb begin
        m_tdata                       = '0;
        m_tdata[SA_LO +: ADDR_BITS]   = res_src_addr;
        m_tdata[DA_LO +: ADDR_BITS]   = res_dst_addr;
        m_tdata[WE_LO]                = res_write_enable;
        m_tdata[PO_LO +: PIXEL_BITS]  = res_pixel;
        m_tdata[BZ_LO]                = res_busy;
    end

endmodule

[test/mirrored_clipped_blit_generator_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for mirrored_clipped_blit_generator: directed and random blit jobs.
// Predicts every result beat from its own copy of the job walk; depends on mcb_pkg and the block under test.
module mirrored_clipped_blit_generator_test import mcb_pkg::*;;

    localparam int S_BITS     = 96;
    localparam int M_BITS     = 72;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    // Register index past the geometry registers; writes to it are dropped
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        mcb_cmd_t           cmd;
        logic [11:0]        src_x;
        logic [11:0]        src_y;
        logic signed [13:0] rect_w;
        logic signed [13:0] rect_h;
        logic signed [12:0] dst_x;
        logic signed [12:0] dst_y;
        logic               overlay;
        logic [15:0]        pixel;
    } blit_item_t;

    typedef struct {
        logic [23:0] src_addr;
        logic [23:0] dst_addr;
        logic        write_en;
        logic [15:0] pixel;
        logic        last;
        logic        busy;
    } blit_result_t;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_BITS-1:0]         s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_BITS-1:0]         m_tdata;
    logic                      m_tlast;

    // Geometry and job state as the block should hold them
    longint src_pitch = 256, dst_w = 256, dst_h = 256;
    longint job_col0, job_row0, job_w, job_h, job_dx, job_dy, walk_col, walk_row;
    logic   flip_cols, flip_rows, colour_key, job_live;

    blit_item_t   pending_items[$];
    blit_result_t blit_expect_q[$];
    blit_item_t   offered_item;

    int send_idle_pct = 0, recv_idle_pct = 0, phase_idx = -1;
    int fail_count = 0, beats_in = 0, starts_in = 0, beats_out = 0, pixels_written = 0;
    int geometry_writes = 0, quiet_cycles = 0, hold_left = 0;
    logic held_off = 1'b0;

    mirrored_clipped_blit_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Saturate a signed size to its magnitude, at most 2^12
    function automatic longint size_magnitude(longint v);
        longint a;
        a = (v < 0) ? -v : v;
        return (a > 4096) ? 4096 : a;
    endfunction

    // Work out the result beat of one accepted input beat and advance the walk
    function automatic blit_result_t blit_predict(blit_item_t it);
        blit_result_t r;
        longint       w, h, scol, srow, dx, dy, sa, da;
        r = '{src_addr: '0, dst_addr: '0, write_en: 1'b0, pixel: it.pixel,
              last: 1'b0, busy: 1'b0};
        if (it.cmd == CMD_START) begin
            w = it.rect_w;
            h = it.rect_h;
            job_col0   = it.src_x;
            job_row0   = it.src_y;
            flip_cols  = w < 0;
            flip_rows  = h < 0;
            job_w      = size_magnitude(w);
            job_h      = size_magnitude(h);
            job_dx     = it.dst_x;
            job_dy     = it.dst_y;
            colour_key = it.overlay;
            walk_col   = 0;
            walk_row   = 0;
            job_live   = job_w != 0 && job_h != 0;
            r.last     = !job_live;
        end else if (!job_live) begin
            r.last = 1'b1;
        end else begin
            scol = job_col0 + (flip_cols ? job_w - 1 - walk_col : walk_col);
            srow = job_row0 + (flip_rows ? job_h - 1 - walk_row : walk_row);
            dx = job_dx + walk_col;
            dy = job_dy + walk_row;
            sa = srow * src_pitch + scol;
            r.src_addr = sa[23:0];
            // Clip against the destination image, then apply the colour key
            if (dx >= 0 && dx < dst_w && dy >= 0 && dy < dst_h) begin
                da = dy * dst_w + dx;
                r.dst_addr = da[23:0];
                r.write_en = !colour_key || it.pixel != 0;
            end
            if (walk_col + 1 >= job_w) begin
                walk_col = 0;
                if (walk_row + 1 >= job_h) begin
                    walk_row = 0;
                    job_live = 1'b0;
                    r.last   = 1'b1;
                end else begin
                    walk_row++;
                end
            end else begin
                walk_col++;
            end
        end
        r.busy = job_live;
        return r;
    endfunction

    function automatic blit_item_t start_item(longint sx, longint sy, longint w, longint h,
                                              longint dx, longint dy, logic ov);
        blit_item_t it;
        it.cmd     = CMD_START;
        it.src_x   = sx[11:0];
        it.src_y   = sy[11:0];
        it.rect_w  = w[13:0];
        it.rect_h  = h[13:0];
        it.dst_x   = dx[12:0];
        it.dst_y   = dy[12:0];
        it.overlay = ov;
        it.pixel   = 16'($urandom);
        return it;
    endfunction

    // Step beat: every field but the pixel is random filler
    function automatic blit_item_t step_item(logic [15:0] pix);
        blit_item_t it;
        it = start_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        1'($urandom_range(0, 1)));
        it.cmd   = CMD_STEP;
        it.pixel = pix;
        return it;
    endfunction

    function automatic logic [15:0] random_pixel();
        return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    endfunction

    // Destination coordinate, mostly within the span or just past its ends
    function automatic longint edge_coord(longint span);
        longint v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom;
        end else begin
            v = longint'($urandom_range(0, int'(span) + 10)) - 6;
            if (v > 4095) v = 4095;
        end
        return v;
    endfunction

    function automatic logic [S_BITS-1:0] pack_item(blit_item_t it);
        return {1'b0, it.pixel, it.overlay, it.dst_y, it.dst_x, it.rect_h, it.rect_w,
                it.src_y, it.src_x};
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Write one geometry register and mirror it into the prediction
    task automatic write_geometry(logic [CFG_INDEX_BITS-1:0] idx, longint value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        geometry_writes++;
        case (idx)
            CFG_SRC_WIDTH:  src_pitch = value[CFG_BITS-1:0];
            CFG_DST_WIDTH:  dst_w     = value[CFG_BITS-1:0];
            CFG_DST_HEIGHT: dst_h     = value[CFG_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(longint sp, longint dw, longint dh);
        write_geometry(CFG_SRC_WIDTH, sp);
        write_geometry(CFG_DST_WIDTH, dw);
        write_geometry(CFG_DST_HEIGHT, dh);
    endtask

    // Hold until every beat is sent and every result has come back
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || blit_expect_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Queue random jobs: mostly whole walks, some cut short, oversized or noise
    task automatic fill_phase(int count);
        int         added, kind, steps;
        longint     w, h;
        blit_item_t it;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                it = start_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1) == 1) it.cmd = CMD_STEP;
                pending_items.push_back(it);
                added++;
            end else begin
                if (kind == 1) begin
                    w = $urandom;
                    h = $urandom;
                    steps = $urandom_range(0, 4);
                end else begin
                    w = $urandom_range(0, 5);
                    h = $urandom_range(0, 4);
                    if ($urandom_range(0, 1) == 1) w = -w;
                    if ($urandom_range(0, 1) == 1) h = -h;
                    steps = int'(size_magnitude(w) * size_magnitude(h));
                    if (kind == 2)
                        steps = $urandom_range(0, steps);
                    else if ($urandom_range(0, 3) == 0)
                        steps++;
                end
                pending_items.push_back(start_item($urandom, $urandom, w, h, edge_coord(dst_w),
                                                   edge_coord(dst_h),
                                                   1'($urandom_range(0, 1))));
                repeat (steps) pending_items.push_back(step_item(random_pixel()));
                added += steps + 1;
            end
        end
    endtask

    // Input driver: offer queued beats, predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                blit_expect_q.push_back(blit_predict(offered_item));
                beats_in++;
                if (offered_item.cmd == CMD_START) starts_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered_item = pending_items.pop_front();
                    s_tdata  <= pack_item(offered_item);
                    s_tuser  <= offered_item.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off in the pressure phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            held_off  <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase_idx == 2 && !held_off && m_tvalid) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            held_off  <= 1'b1;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // Result checker: compare each beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        blit_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (m_tdata[48]) pixels_written++;
            if (blit_expect_q.size() == 0) begin
                $error("result beat with no input beat waiting for it");
                fail_count++;
            end else begin
                want = blit_expect_q.pop_front();
                check_field("src_addr", want.src_addr, m_tdata[23:0]);
                check_field("dst_addr", want.dst_addr, m_tdata[47:24]);
                check_field("write_enable", want.write_en, m_tdata[48]);
                check_field("pixel_out", want.pixel, m_tdata[64:49]);
                check_field("busy_res", want.busy, m_tdata[65]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("mirrored_clipped_blit_generator: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: small image, full pitch, and a write to the spare index
        set_geometry(4096, 8, 6);
        write_geometry(CFG_SPARE, 8191);
        send_idle_pct = 32;
        recv_idle_pct = 60;
        // step with no job
        pending_items.push_back(step_item(16'h1234));
        // keyed 3x2 at the far source corner, clipped left and below
        pending_items.push_back(start_item(4095, 4095, 3, 2, -1, 5, 1'b1));
        pending_items.push_back(step_item(16'h0000));
        pending_items.push_back(step_item(16'hFFFF));
        pending_items.push_back(step_item(16'h0001));
        pending_items.push_back(step_item(16'h0000));
        pending_items.push_back(step_item(16'h8000));
        pending_items.push_back(step_item(16'h00FF));
        // mirrored both ways, plain copy writes zero pixels
        pending_items.push_back(start_item(0, 0, -2, -2, 6, 4, 1'b0));
        pending_items.push_back(step_item(16'h0000));
        pending_items.push_back(step_item(16'h0000));
        pending_items.push_back(step_item(16'hABCD));
        pending_items.push_back(step_item(16'h0000));
        // empty job, then a step after it
        pending_items.push_back(start_item(12, 34, 0, 5, 0, 0, 1'b0));
        pending_items.push_back(step_item(16'h5A5A));
        // oversized sizes at the coordinate extremes, then replaced while busy
        pending_items.push_back(start_item(2047, 1, 8191, -8192, -4096, 4095, 1'b1));
        pending_items.push_back(step_item(16'h7FFF));
        pending_items.push_back(step_item(16'h0000));
        pending_items.push_back(start_item(4095, 0, 1, 1, 0, 0, 1'b1));
        pending_items.push_back(step_item(16'h0000));
        pending_items.push_back(step_item(16'h0042));
        pending_items.push_back(start_item(0, 0, 4096, -4096, 4095, -4096, 1'b0));
        pending_items.push_back(step_item(16'hC3C3));
        wait_idle();

        // Random phases, each with its own geometry and idling pattern
        for (int p = 0; p < 4; p++) begin
            phase_idx = p;
            case (p)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 60;
                    set_geometry(1, 4096, 4096);
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 32;
                    set_geometry($urandom_range(1, 4096), 0, $urandom_range(1, 64));
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_geometry($urandom_range(1, 300), $urandom_range(1, 40),
                                 $urandom_range(1, 40));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_geometry(4096, $urandom_range(1, 4096), $urandom_range(1, 4096));
                end
            endcase
            fill_phase(125);
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        $display("run covered %0d input beats (%0d job starts), %0d results, %0d pixels written",
                 beats_in, starts_in, beats_out, pixels_written);
        $display("geometry writes: %0d over five settings, including zero and 4096 sizes",
                 geometry_writes);
        if (fail_count == 0) begin
            $display("mirrored_clipped_blit_generator: match");
        end else begin
            $display("mirrored_clipped_blit_generator: mismatch");
        end
        $finish;
    end

endmodule

[mirrored_clipped_blit_generator.f]
hw/rtl/mcb_pkg.sv
hw/rtl/mcb_job.sv
hw/rtl/mcb_addr.sv
hw/rtl/mirrored_clipped_blit_generator.sv
test/mirrored_clipped_blit_generator_test.sv
